>>> rtl/mia_pkg.sv
package mia_pkg;

  // one request into the alu
  typedef struct packed {
    logic [5:0]  command;
    logic [5:0]  function_code;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
  } in_t;

  // one request out of the alu
  typedef struct packed {
    logic [31:0] result;
    logic [31:0] hi_out;
    logic [31:0] lo_out;
    logic        not_implemented;
  } out_t;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;

  // r-type function codes
  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_DIV   = 6'h1A;
  localparam logic [5:0] FN_DIVU  = 6'h1B;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_SUBU  = 6'h23;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_SLT   = 6'h2A;

endpackage

>>> rtl/mips_integer_alu.sv
// Integer ALU for the MIPS32 R-type and immediate arithmetic, logic, shift and compare
// operations, with MULT/MULTU and DIV/DIVU into the kept HI and LO registers. Each
// request gives exactly one answer carrying the result, HI and LO after the operation
// and a not-implemented flag. Simple operations pass through capture, decode and hand-off
// to the output register. Multiply and divide run a one-bit-per-cycle shift/add (multiply)
// or shift/subtract (divide) loop of 32 iterations through the acc/sh working registers,
// followed by the FIX1 and FIX2 correction states for the signed adjustments; a divide by
// zero skips the loop. One request is in flight at a time; a new request is taken the cycle
// after the previous answer moves into the output register, even while that answer
// still waits on out_stall_i. No clearing pass after reset.
module mips_integer_alu (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mia_pkg::in_t  in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mia_pkg::out_t out_req_o
);
  import mia_pkg::*;

  // sequencer codes
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_ITER   = 3'd2;
  localparam logic [2:0] ST_FIX1   = 3'd3;
  localparam logic [2:0] ST_FIX2   = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  // 32 iterations of the serial loop
  localparam logic [4:0] CntLast = 5'd31;

  // control state
  logic [2:0]  state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] hi_q, hi_d;
  logic [31:0] lo_q, lo_d;

  // captured request and working registers
  logic [5:0]  cmd_q, cmd_d;
  logic [5:0]  fn_q, fn_d;
  logic [31:0] opa_q, opa_d;
  logic [31:0] opb_q, opb_d;
  logic [31:0] dv_q, dv_d;     // divisor magnitude
  logic [31:0] acc_q, acc_d;   // partial product high half / partial remainder
  logic [31:0] sh_q, sh_d;     // multiplier-product low half / dividend-quotient
  logic [31:0] res_q, res_d;
  logic        bad_q, bad_d;
  logic        is_div_q, is_div_d;
  logic        is_sgn_q, is_sgn_d;
  logic        neg_q, neg_d;   // quotient negative
  logic        na_q, na_d;     // dividend negative
  out_t        out_q, out_d;

  // decode and simple-operation datapath
  logic [4:0]  sh_amt;
  logic [31:0] imm_s;
  logic [31:0] imm_z;
  logic [31:0] simple_res;
  logic        simple_bad;
  logic        md_op;
  logic        md_div;
  logic        md_sgn;

  // serial loop datapath
  logic [32:0] msum;
  logic [32:0] rshift;
  logic [33:0] trial;
  logic [31:0] corr1;
  logic [31:0] corr2;

  always_comb begin
    sh_amt     = opb_q[4:0];
    imm_s      = {{16{opb_q[15]}}, opb_q[15:0]};
    imm_z      = {16'h0000, opb_q[15:0]};
    simple_res = '0;
    simple_bad = 1'b0;
    md_op      = 1'b0;
    md_div     = 1'b0;
    md_sgn     = 1'b0;
    if (cmd_q == OP_SPECIAL) begin
      case (fn_q)
        FN_SLL: simple_res = opa_q << sh_amt;
        FN_SRL: simple_res = opa_q >> sh_amt;
        FN_SRA: simple_res = $unsigned($signed(opa_q) >>> sh_amt);
        FN_MULT: begin
          md_op  = 1'b1;
          md_sgn = 1'b1;
        end
        FN_MULTU: md_op = 1'b1;
        FN_DIV: begin
          md_op  = 1'b1;
          md_div = 1'b1;
          md_sgn = 1'b1;
        end
        FN_DIVU: begin
          md_op  = 1'b1;
          md_div = 1'b1;
        end
        FN_ADD, FN_ADDU: simple_res = opa_q + opb_q;
        FN_SUB, FN_SUBU: simple_res = opa_q - opb_q;
        FN_AND: simple_res = opa_q & opb_q;
        FN_OR:  simple_res = opa_q | opb_q;
        FN_XOR: simple_res = opa_q ^ opb_q;
        FN_NOR: simple_res = ~(opa_q | opb_q);
        FN_SLT: simple_res = {31'd0, $signed(opa_q) < $signed(opb_q)};
        default: simple_bad = 1'b1;
      endcase
    end else begin
      case (cmd_q)
        OP_ADDI, OP_ADDIU: simple_res = opa_q + imm_s;
        OP_SLTI: simple_res = {31'd0, $signed(opa_q) < $signed(imm_s)};
        OP_ANDI: simple_res = opa_q & imm_z;
        OP_ORI:  simple_res = opa_q | imm_z;
        OP_XORI: simple_res = opa_q ^ imm_z;
        default: simple_bad = 1'b1;
      endcase
    end
  end

  // shift/add step for multiply, shift/subtract step for divide
  assign msum   = {1'b0, acc_q} + {1'b0, (sh_q[0] ? opa_q : 32'd0)};
  assign rshift = {acc_q, sh_q[31]};
  assign trial  = {1'b0, rshift} - {2'b00, dv_q};

  // signed product from the unsigned one: subtract the cross terms from hi
  assign corr1 = (is_sgn_q && opa_q[31]) ? opb_q : 32'd0;
  assign corr2 = (is_sgn_q && opb_q[31]) ? opa_q : 32'd0;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    cmd_d       = cmd_q;
    fn_d        = fn_q;
    opa_d       = opa_q;
    opb_d       = opb_q;
    dv_d        = dv_q;
    acc_d       = acc_q;
    sh_d        = sh_q;
    res_d       = res_q;
    bad_d       = bad_q;
    is_div_d    = is_div_q;
    is_sgn_d    = is_sgn_q;
    neg_d       = neg_q;
    na_d        = na_q;
    out_d       = out_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = in_req_i.command;
          fn_d    = in_req_i.function_code;
          opa_d   = in_req_i.operand_a;
          opb_d   = in_req_i.operand_b;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        res_d    = md_op ? 32'd1 : simple_res;
        bad_d    = simple_bad;
        is_div_d = md_div;
        is_sgn_d = md_sgn;
        neg_d    = opa_q[31] ^ opb_q[31];
        na_d     = opa_q[31];
        cnt_d    = '0;
        acc_d    = '0;
        if (md_op && md_div) begin
          // divide by zero leaves hi and lo alone
          if (opb_q == 32'd0) begin
            state_d = ST_DONE;
          end else begin
            dv_d    = (md_sgn && opb_q[31]) ? (~opb_q + 32'd1) : opb_q;
            sh_d    = (md_sgn && opa_q[31]) ? (~opa_q + 32'd1) : opa_q;
            state_d = ST_ITER;
          end
        end else if (md_op) begin
          sh_d    = opb_q;
          state_d = ST_ITER;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_ITER: begin
        if (is_div_q) begin
          acc_d = trial[33] ? rshift[31:0] : trial[31:0];
          sh_d  = {sh_q[30:0], ~trial[33]};
        end else begin
          acc_d = msum[32:1];
          sh_d  = {msum[0], sh_q[31:1]};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == CntLast) begin
          state_d = ST_FIX1;
        end
      end
      ST_FIX1: begin
        if (is_div_q) begin
          lo_d = (is_sgn_q && neg_q) ? (~sh_q + 32'd1) : sh_q;
        end else begin
          hi_d = acc_q - corr1;
          lo_d = sh_q;
        end
        state_d = ST_FIX2;
      end
      ST_FIX2: begin
        if (is_div_q) begin
          // remainder follows the dividend sign
          hi_d = (is_sgn_q && na_q) ? (~acc_q + 32'd1) : acc_q;
        end else begin
          hi_d = hi_q - corr2;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.result          = res_q;
          out_d.hi_out          = hi_q;
          out_d.lo_out          = lo_q;
          out_d.not_implemented = bad_q;
          out_valid_d           = 1'b1;
          state_d               = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      hi_q        <= '0;
      lo_q        <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      hi_q        <= hi_d;
      lo_q        <= lo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    fn_q     <= fn_d;
    opa_q    <= opa_d;
    opb_q    <= opb_d;
    dv_q     <= dv_d;
    acc_q    <= acc_d;
    sh_q     <= sh_d;
    res_q    <= res_d;
    bad_q    <= bad_d;
    is_div_q <= is_div_d;
    is_sgn_q <= is_sgn_d;
    neg_q    <= neg_d;
    na_q     <= na_d;
    out_q    <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

`ifndef ASSERT_OFF
  // an accepted request always goes to decode next
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == ST_DECODE)
    else $error("accepted request did not enter decode");

  // decode never touches hi or lo
  a_decode_keeps_hilo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DECODE |=> hi_q == $past(hi_q) && lo_q == $past(lo_q))
    else $error("hi/lo changed during decode");

  // the serial loop runs exactly 32 steps before the corrections
  a_loop_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ITER && cnt_q == CntLast |=> state_q == ST_FIX1)
    else $error("serial loop did not end after 32 steps");

  // the answer register is never overwritten while it waits
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && out_valid_q && out_stall_i |=> state_q == ST_DONE)
    else $error("pending answer overwritten");
`endif

endmodule

>>> bench/tb_top.sv
module tb_top;
  import mia_pkg::*;

  // watchdog limit, several times the slowest legal run
  localparam int unsigned CYCLE_LIMIT = 400000;
  // answer latency of a multiply or divide, plus margin
  localparam int unsigned DRAIN_CYCLES = 48;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_req_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_req_o;

  // predicted hi/lo registers, updated in request acceptance order
  logic [31:0] hi_pred;
  logic [31:0] lo_pred;

  // answers still owed by the alu, oldest first
  out_t pending_answers[$];

  int unsigned error_count;
  int unsigned tick_count;

  // idle controls shared between the test tasks and the two sides
  bit          send_gaps_on;
  bit          recv_stalls_on;
  int unsigned hold_off_left;
  int unsigned stall_left;

  mips_integer_alu u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o)
  );

  always #5 clk_i = ~clk_i;

  // -------------------------------------------------------------------------
  // prediction: one answer per request, hi/lo kept across requests
  // -------------------------------------------------------------------------
  function automatic out_t alu_answer(input in_t req);
    out_t        ans;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] imm_sext;
    logic [31:0] imm_zext;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] quo;
    logic [31:0] rem;
    logic [63:0] prod;
    logic [4:0]  shamt;
    a        = req.operand_a;
    b        = req.operand_b;
    shamt    = b[4:0];
    imm_sext = {{16{b[15]}}, b[15:0]};
    imm_zext = {16'h0000, b[15:0]};
    ans      = '0;
    if (req.command == OP_SPECIAL) begin
      case (req.function_code)
        FN_SLL: ans.result = a << shamt;
        FN_SRL: ans.result = a >> shamt;
        // sign bit of a fills in from the top
        FN_SRA: ans.result = $unsigned($signed(a) >>> shamt);
        FN_MULT: begin
          // low 64 bits of the sign-extended product equal the signed product
          prod   = {{32{a[31]}}, a} * {{32{b[31]}}, b};
          hi_pred = prod[63:32];
          lo_pred = prod[31:0];
          ans.result = 32'd1;
        end
        FN_MULTU: begin
          prod   = {32'h0, a} * {32'h0, b};
          hi_pred = prod[63:32];
          lo_pred = prod[31:0];
          ans.result = 32'd1;
        end
        FN_DIV: begin
          // divide by zero keeps hi/lo as they were
          if (b != 32'h0) begin
            mag_a = a[31] ? (~a + 32'd1) : a;
            mag_b = b[31] ? (~b + 32'd1) : b;
            quo   = mag_a / mag_b;
            rem   = mag_a % mag_b;
            // truncation toward zero, remainder follows the dividend
            lo_pred = (a[31] != b[31]) ? (~quo + 32'd1) : quo;
            hi_pred = a[31] ? (~rem + 32'd1) : rem;
          end
          ans.result = 32'd1;
        end
        FN_DIVU: begin
          if (b != 32'h0) begin
            lo_pred = a / b;
            hi_pred = a % b;
          end
          ans.result = 32'd1;
        end
        // add and sub wrap, no overflow trap
        FN_ADD, FN_ADDU: ans.result = a + b;
        FN_SUB, FN_SUBU: ans.result = a - b;
        FN_AND:  ans.result = a & b;
        FN_OR:   ans.result = a | b;
        FN_XOR:  ans.result = a ^ b;
        FN_NOR:  ans.result = ~(a | b);
        FN_SLT:  ans.result = {31'h0, $signed(a) < $signed(b)};
        default: ans.not_implemented = 1'b1;
      endcase
    end else begin
      case (req.command)
        OP_ADDI, OP_ADDIU: ans.result = a + imm_sext;
        OP_SLTI: ans.result = {31'h0, $signed(a) < $signed(imm_sext)};
        OP_ANDI: ans.result = a & imm_zext;
        OP_ORI:  ans.result = a | imm_zext;
        OP_XORI: ans.result = a ^ imm_zext;
        default: ans.not_implemented = 1'b1;
      endcase
    end
    ans.hi_out = hi_pred;
    ans.lo_out = lo_pred;
    return ans;
  endfunction

  // -------------------------------------------------------------------------
  // stimulus helpers
  // -------------------------------------------------------------------------

  // mostly back to back, sometimes a short gap, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_t make_request(input logic [5:0] cmd, input logic [5:0] fn,
                                       input logic [31:0] a, input logic [31:0] b);
    in_t req;
    req.command       = cmd;
    req.function_code = fn;
    req.operand_a     = a;
    req.operand_b     = b;
    return req;
  endfunction

  function automatic logic [5:0] pick_rtype_fn();
    case ($urandom_range(0, 15))
      0:       return FN_SLL;
      1:       return FN_SRL;
      2:       return FN_SRA;
      3:       return FN_MULT;
      4:       return FN_MULTU;
      5:       return FN_DIV;
      6:       return FN_DIVU;
      7:       return FN_ADD;
      8:       return FN_ADDU;
      9:       return FN_SUB;
      10:      return FN_SUBU;
      11:      return FN_AND;
      12:      return FN_OR;
      13:      return FN_XOR;
      14:      return FN_NOR;
      default: return FN_SLT;
    endcase
  endfunction

  function automatic logic [5:0] pick_imm_op();
    case ($urandom_range(0, 5))
      0:       return OP_ADDI;
      1:       return OP_ADDIU;
      2:       return OP_SLTI;
      3:       return OP_ANDI;
      4:       return OP_ORI;
      default: return OP_XORI;
    endcase
  endfunction

  // operands lean on corners: zero divisors, -1, most negative, small values
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 15))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h8000_0000;
      4:       return 32'h7FFF_FFFF;
      5:       return $urandom_range(0, 40);
      6:       return 32'hFFFF_0000 | $urandom_range(0, 65535);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t random_request();
    int unsigned kind;
    logic [5:0]  cmd;
    logic [5:0]  fn;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      cmd = OP_SPECIAL;
      fn  = pick_rtype_fn();
    end else if (kind < 85) begin
      // function field is don't-care here, keep it random
      cmd = pick_imm_op();
      fn  = 6'($urandom_range(0, 63));
    end else begin
      // anything at all, mostly unsupported codes
      cmd = 6'($urandom_range(0, 63));
      fn  = 6'($urandom_range(0, 63));
    end
    return make_request(cmd, fn, pick_operand(), pick_operand());
  endfunction

  // offer one request, hold it until taken, then maybe idle the input
  task automatic send_request(input in_t req);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o);
    pending_answers.push_back(alu_answer(req));
    gap = send_gaps_on ? idle_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // -------------------------------------------------------------------------
  // output side: check every accepted answer, then choose the next stall
  // -------------------------------------------------------------------------
  task automatic check_answer(input out_t got);
    out_t want;
    if (pending_answers.size() == 0) begin
      $display("%0t: answer with nothing pending: result %h hi %h lo %h ni %b",
               $time, got.result, got.hi_out, got.lo_out, got.not_implemented);
      error_count++;
    end else begin
      want = pending_answers.pop_front();
      if (got.result !== want.result) begin
        $display("%0t: result mismatch: expected %h actual %h",
                 $time, want.result, got.result);
        error_count++;
      end
      if (got.hi_out !== want.hi_out) begin
        $display("%0t: hi mismatch: expected %h actual %h",
                 $time, want.hi_out, got.hi_out);
        error_count++;
      end
      if (got.lo_out !== want.lo_out) begin
        $display("%0t: lo mismatch: expected %h actual %h",
                 $time, want.lo_out, got.lo_out);
        error_count++;
      end
      if (got.not_implemented !== want.not_implemented) begin
        $display("%0t: not_implemented mismatch: expected %b actual %b",
                 $time, want.not_implemented, got.not_implemented);
        error_count++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    // values seen here are the ones from before this edge
    if (rst_ni && out_valid_o && !out_stall_i) begin
      check_answer(out_req_o);
    end
    if (hold_off_left != 0) begin
      // long hold-off so the alu backs up into its input
      out_stall_i   <= 1'b1;
      hold_off_left <= hold_off_left - 1;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  = stall_left - 1;
    end else begin
      stall_left  = recv_stalls_on ? idle_len() : 0;
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left = stall_left - 1;
    end
  end

  // -------------------------------------------------------------------------
  // tests
  // -------------------------------------------------------------------------

  // shift by zero and 31, amount taken from the low five bits only
  task automatic test_shifts();
    send_request(make_request(OP_SPECIAL, FN_SLL, 32'h8000_0001, 32'd0));
    send_request(make_request(OP_SPECIAL, FN_SLL, 32'hFFFF_FFFF, 32'd31));
    send_request(make_request(OP_SPECIAL, FN_SRL, 32'hFFFF_FFFF, 32'hFFFF_FFE4));
    send_request(make_request(OP_SPECIAL, FN_SRA, 32'h8000_0000, 32'd31));
    send_request(make_request(OP_SPECIAL, FN_SRA, 32'h7FFF_FFFF, 32'd4));
  endtask

  // add wraps without a trap, signed compares on both sides of zero
  task automatic test_arith_logic();
    send_request(make_request(OP_SPECIAL, FN_ADD, 32'h7FFF_FFFF, 32'h0000_0001));
    send_request(make_request(OP_SPECIAL, FN_ADDU, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_request(OP_SPECIAL, FN_SUB, 32'h0000_0000, 32'h0000_0001));
    send_request(make_request(OP_SPECIAL, FN_SUBU, 32'h8000_0000, 32'h7FFF_FFFF));
    send_request(make_request(OP_SPECIAL, FN_AND, 32'hF0F0_F0F0, 32'hFFFF_0000));
    send_request(make_request(OP_SPECIAL, FN_OR, 32'h0000_0000, 32'h0000_0000));
    send_request(make_request(OP_SPECIAL, FN_XOR, 32'hFFFF_FFFF, 32'hAAAA_5555));
    send_request(make_request(OP_SPECIAL, FN_NOR, 32'h0000_0000, 32'h0000_0000));
    send_request(make_request(OP_SPECIAL, FN_SLT, 32'h8000_0000, 32'h7FFF_FFFF));
    send_request(make_request(OP_SPECIAL, FN_SLT, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
  endtask

  // signed/unsigned products, rounding, most-negative by -1, divide by zero
  task automatic test_mult_div();
    send_request(make_request(OP_SPECIAL, FN_MULT, 32'h8000_0000, 32'h8000_0000));
    send_request(make_request(OP_SPECIAL, FN_MULTU, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_request(OP_SPECIAL, FN_MULT, 32'hFFFF_FFFF, 32'h0000_0007));
    send_request(make_request(OP_SPECIAL, FN_DIV, 32'hFFFF_FFF9, 32'h0000_0002));
    send_request(make_request(OP_SPECIAL, FN_DIV, 32'h8000_0000, 32'hFFFF_FFFF));
    send_request(make_request(OP_SPECIAL, FN_DIV, 32'h1234_5678, 32'h0000_0000));
    send_request(make_request(OP_SPECIAL, FN_DIVU, 32'hFFFF_FFFF, 32'h0000_0010));
    send_request(make_request(OP_SPECIAL, FN_DIVU, 32'h0000_0005, 32'h0000_0000));
  endtask

  // immediates: sign-extended for add/slti, zero-extended for logic ops
  task automatic test_immediates();
    send_request(make_request(OP_ADDI, 6'h3F, 32'h0000_0000, 32'h0000_8000));
    send_request(make_request(OP_ADDIU, 6'h00, 32'hFFFF_FFFF, 32'hFFFF_7FFF));
    send_request(make_request(OP_SLTI, 6'h2A, 32'hFFFF_FFFE, 32'h0000_FFFF));
    send_request(make_request(OP_ANDI, 6'h24, 32'hFFFF_FFFF, 32'hFFFF_8001));
    send_request(make_request(OP_ORI, 6'h25, 32'h8000_0000, 32'hFFFF_FFFF));
    send_request(make_request(OP_XORI, 6'h26, 32'hFFFF_FFFF, 32'h0000_FFFF));
  endtask

  // unsupported codes give zero and the flag, hi/lo untouched
  task automatic test_unsupported();
    send_request(make_request(OP_SPECIAL, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_request(6'h3F, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
  endtask

  task automatic test_random_streaming(input int unsigned count);
    send_gaps_on   = 1'b0;
    recv_stalls_on = 1'b0;
    repeat (count) send_request(random_request());
  endtask

  task automatic test_random_idling(input int unsigned count);
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
    repeat (count) send_request(random_request());
  endtask

  // output held off while requests keep coming, so the input must stall
  task automatic test_backpressure(input int unsigned count);
    send_gaps_on   = 1'b0;
    recv_stalls_on = 1'b0;
    hold_off_left <= 300;
    repeat (count) send_request(random_request());
  endtask

  // -------------------------------------------------------------------------
  // watchdog
  // -------------------------------------------------------------------------
  initial begin
    tick_count = 0;
    while (tick_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      tick_count++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_req_i       = '0;
    out_stall_i    = 1'b0;
    hi_pred        = '0;
    lo_pred        = '0;
    error_count    = 0;
    send_gaps_on   = 1'b0;
    recv_stalls_on = 1'b0;
    hold_off_left  = 0;
    stall_left     = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_shifts();
    test_arith_logic();
    test_mult_div();
    test_immediates();
    test_unsupported();
    test_random_streaming(200);
    test_random_idling(550);
    test_backpressure(50);
    in_valid_i <= 1'b0;

    // let the last answers drain, then watch for strays
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
